// ----- design/rsi_pkg.sv -----
// Shared types, constants and helper functions of the ray/sphere intersection unit.
package rsi_pkg;

    // Fixed point format of every coordinate
    localparam int FRAC_BITS = 16;
    localparam int EPS_SHIFT = 12;
    localparam int FIX_W = 32;

    // Unit direction components stay below 2^(FRAC_BITS+1) in magnitude
    localparam int U_W = FRAC_BITS + 2;
    localparam int PROD_W = FIX_W + U_W;
    localparam int ACC_W = PROD_W + 2;
    localparam int PT_W = FIX_W + 2 + U_W - FRAC_BITS;
    localparam int ND_W = PT_W + 1;

    // Pipelined units
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES = 32;

    // Queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);
    localparam logic [63:0] UNIT_TOL = ONE_SQ >> EPS_SHIFT;
    localparam logic signed [63:0] FIX_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] FIX_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef logic signed [FIX_W-1:0] fix_t;
    typedef logic signed [U_W-1:0] unit_t;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        fix_t origin_x;
        fix_t origin_y;
        fix_t origin_z;
        fix_t dir_x;
        fix_t dir_y;
        fix_t dir_z;
    } ray_t;

    typedef struct packed {
        logic        hit;
        fix_t        point_x;
        fix_t        point_y;
        fix_t        point_z;
        fix_t        normal_x;
        fix_t        normal_y;
        fix_t        normal_z;
        logic [30:0] hit_distance;
    } result_t;

    typedef struct packed {
        fix_t        center_x;
        fix_t        center_y;
        fix_t        center_z;
        logic [30:0] sphere_radius;
    } sphere_cfg_t;

    // One classified ray handed from front to back
    typedef struct packed {
        logic            reject;
        fix_t [2:0]      origin;
        fix_t [2:0]      oc;
        unit_t [2:0]     u;
    } queue_entry_t;

    typedef struct packed {
        logic empty;
        logic almost_full;
    } queue_status_t;

    // Clamp a wide signed value to the 32-bit signed range
    function automatic fix_t sat32(input logic signed [63:0] v);
        if (v > FIX_MAX)
            return fix_t'(FIX_MAX);
        if (v < FIX_MIN)
            return fix_t'(FIX_MIN);
        return fix_t'(v);
    endfunction

    // Magnitude of a 32-bit signed value; the most negative value maps to 2^31
    function automatic logic [31:0] mag32(input fix_t v);
        return v[FIX_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage

// ----- design/ray_sphere_intersect_unit.sv -----
// Ray/sphere intersection unit: configuration registers, front end, queue and back end.
// Throughput: one ray per cycle, set by the fully pipelined square root and divider stages.
// The result stands on the result port for one cycle, flagged by done; it cannot be held off.
// Reset clears all valid bits and the queue, and loads center 0 and radius 1.0.
// busy rises only when the queue nears full, which a never-stalling back end does not reach.
module ray_sphere_intersect_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rsi_pkg::ray_t    ray,
    output logic             done,
    output rsi_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import rsi_pkg::*;

    sphere_cfg_t   cfg_reg;
    logic          accept;
    logic          q_push;
    queue_entry_t  q_wr_data;
    logic          q_pop;
    queue_entry_t  q_rd_data;
    queue_status_t q_status;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
            cfg_reg.center_z <= '0;
            cfg_reg.sphere_radius <= 31'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: cfg_reg.center_x <= cfg_data;
                REG_CENTER_Y: cfg_reg.center_y <= cfg_data;
                REG_CENTER_Z: cfg_reg.center_z <= cfg_data;
                REG_RADIUS:   cfg_reg.sphere_radius <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // Take a transaction when started and not held off
    assign accept = start && !busy;
    assign busy = q_status.almost_full;

    rsi_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ray    (ray),
        .cfg    (cfg_reg),
        .push   (q_push),
        .entry  (q_wr_data)
    );

    rsi_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    rsi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (q_rd_data),
        .cfg      (cfg_reg),
        .pop      (q_pop),
        .done     (done),
        .result   (result)
    );

endmodule

// ----- design/rsi_isqrt.sv -----
// Fully pipelined 64-bit integer square root, one result bit per stage.
module rsi_isqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import rsi_pkg::*;

    logic [63:0] x_reg   [SQRT_STAGES];
    logic [63:0] res_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT_V = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
        logic [63:0] x_in;
        logic [63:0] res_in;
        logic [63:0] trial;

        // Pick up the previous stage, or the radicand at the head
        if (k == 0) begin : g_head
            assign x_in = radicand;
            assign res_in = '0;
        end else begin : g_body
            assign x_in = x_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial = res_in + BIT_V;

        // Subtract the trial value when it fits and set this root bit
        always_ff @(posedge clk)
        begin
            if (x_in >= trial)
            begin
                x_reg[k] <= x_in - trial;
                res_reg[k] <= (res_in >> 1) + BIT_V;
            end
            else
            begin
                x_reg[k] <= x_in;
                res_reg[k] <= res_in >> 1;
            end
        end
    end

    assign root = res_reg[SQRT_STAGES-1][31:0];

endmodule

// ----- design/rsi_div.sv -----
// Fully pipelined restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a stage.
module rsi_div (
    input  logic        clk,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient
);
    import rsi_pkg::*;

    logic [63:0]           rem_reg [DIV_STAGES];
    logic [31:0]           den_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_reg   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int SHIFT = DIV_STAGES - 1 - k;
        logic [63:0]           rem_in;
        logic [31:0]           den_in;
        logic [DIV_STAGES-1:0] q_in;
        logic [63:0]           den_shifted;

        // Pick up the previous stage, or the operands at the head
        if (k == 0) begin : g_head
            assign rem_in = dividend;
            assign den_in = divisor;
            assign q_in = '0;
        end else begin : g_body
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        assign den_shifted = 64'(den_in) << SHIFT;

        // Subtract the aligned divisor when it fits and shift in the quotient bit
        always_ff @(posedge clk)
        begin
            den_reg[k] <= den_in;
            if (rem_in >= den_shifted)
            begin
                rem_reg[k] <= rem_in - den_shifted;
                q_reg[k] <= {q_in[DIV_STAGES-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k] <= rem_in;
                q_reg[k] <= {q_in[DIV_STAGES-2:0], 1'b0};
            end
        end
    end

    assign quotient = q_reg[DIV_STAGES-1][31:0];

endmodule

// ----- design/rsi_front.sv -----
// Front end: takes rays, computes center offset and the unit direction, and queues them.
module rsi_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  rsi_pkg::ray_t         ray,
    input  rsi_pkg::sphere_cfg_t  cfg,
    output logic                  push,
    output rsi_pkg::queue_entry_t entry
);
    import rsi_pkg::*;

    typedef struct packed {
        logic       zero;
        logic       unit;
        fix_t [2:0] o;
        fix_t [2:0] d;
        fix_t [2:0] oc;
    } front_side_t;

    // Stage 0: captured ray
    logic       v0_reg;
    fix_t [2:0] o0_reg;
    fix_t [2:0] d0_reg;

    // Stage 1: squares and center offset
    logic        v1_reg;
    logic [63:0] dd1_reg [3];
    fix_t [2:0]  o1_reg;
    fix_t [2:0]  d1_reg;
    fix_t [2:0]  oc1_reg;

    // Stage 2: squared length and classification
    logic        v2_reg;
    logic [63:0] s2_reg;
    front_side_t side2_reg;
    logic [63:0] s_sum;
    logic [63:0] s_dev;

    // Square root line
    logic [SQRT_STAGES-1:0] vsq_reg;
    front_side_t            side_sq_reg [SQRT_STAGES];
    logic [31:0]            len_root;

    // Stage 3: rounded dividends
    logic        v3_reg;
    logic [63:0] num3_reg [3];
    logic [31:0] len3_reg;
    logic [2:0]  neg3_reg;
    front_side_t side3_reg;

    // Divider line
    logic [DIV_STAGES-1:0] vdv_reg;
    front_side_t           side_dv_reg [DIV_STAGES];
    logic [2:0]            neg_dv_reg  [DIV_STAGES];
    logic [31:0]           quot [3];

    // Stage 4: queued entry
    logic         v4_reg;
    queue_entry_t entry4_reg;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vsq_reg <= '0;
            v3_reg <= 1'b0;
            vdv_reg <= '0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            vsq_reg <= {vsq_reg[SQRT_STAGES-2:0], v2_reg};
            v3_reg <= vsq_reg[SQRT_STAGES-1];
            vdv_reg <= {vdv_reg[DIV_STAGES-2:0], v3_reg};
            v4_reg <= vdv_reg[DIV_STAGES-1];
        end
    end

    // Capture the ray on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            o0_reg <= {ray.origin_z, ray.origin_y, ray.origin_x};
            d0_reg <= {ray.dir_z, ray.dir_y, ray.dir_x};
        end
    end

    // Square the direction and offset the center
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd1_reg[i] <= d0_reg[i] * d0_reg[i];
        end
        oc1_reg[0] <= sat32(64'(cfg.center_x) - 64'(o0_reg[0]));
        oc1_reg[1] <= sat32(64'(cfg.center_y) - 64'(o0_reg[1]));
        oc1_reg[2] <= sat32(64'(cfg.center_z) - 64'(o0_reg[2]));
        o1_reg <= o0_reg;
        d1_reg <= d0_reg;
    end

    // Sum the squares and test for unit length
    always_comb
    begin
        s_sum = dd1_reg[0] + dd1_reg[1] + dd1_reg[2];
        s_dev = (s_sum > ONE_SQ) ? (s_sum - ONE_SQ) : (ONE_SQ - s_sum);
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s_sum;
        side2_reg.zero <= (s_sum == 64'd0);
        side2_reg.unit <= (s_dev <= UNIT_TOL);
        side2_reg.o <= o1_reg;
        side2_reg.d <= d1_reg;
        side2_reg.oc <= oc1_reg;
    end

    rsi_isqrt u_len_sqrt (
        .clk      (clk),
        .radicand (s2_reg),
        .root     (len_root)
    );

    // Hold ray data alongside the square root
    always_ff @(posedge clk)
    begin
        side_sq_reg[0] <= side2_reg;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            side_sq_reg[k] <= side_sq_reg[k-1];
        end
    end

    // Form |d| * one + len / 2 for rounded division
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num3_reg[i] <= (64'(mag32(side_sq_reg[SQRT_STAGES-1].d[i])) << FRAC_BITS)
                           + 64'(len_root >> 1);
            neg3_reg[i] <= side_sq_reg[SQRT_STAGES-1].d[i][FIX_W-1];
        end
        len3_reg <= len_root;
        side3_reg <= side_sq_reg[SQRT_STAGES-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_norm_div
        rsi_div u_div (
            .clk      (clk),
            .dividend (num3_reg[i]),
            .divisor  (len3_reg),
            .quotient (quot[i])
        );
    end

    // Hold ray data alongside the dividers
    always_ff @(posedge clk)
    begin
        side_dv_reg[0] <= side3_reg;
        neg_dv_reg[0] <= neg3_reg;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            side_dv_reg[k] <= side_dv_reg[k-1];
            neg_dv_reg[k] <= neg_dv_reg[k-1];
        end
    end

    // Select the given or the normalized direction and build the entry
    always_ff @(posedge clk)
    begin
        entry4_reg.reject <= side_dv_reg[DIV_STAGES-1].zero;
        entry4_reg.origin <= side_dv_reg[DIV_STAGES-1].o;
        entry4_reg.oc <= side_dv_reg[DIV_STAGES-1].oc;
        for (int i = 0; i < 3; i++)
        begin
            if (side_dv_reg[DIV_STAGES-1].unit)
                entry4_reg.u[i] <= side_dv_reg[DIV_STAGES-1].d[i][U_W-1:0];
            else if (neg_dv_reg[DIV_STAGES-1][i])
                entry4_reg.u[i] <= -quot[i][U_W-1:0];
            else
                entry4_reg.u[i] <= quot[i][U_W-1:0];
        end
    end

    assign push = v4_reg;
    assign entry = entry4_reg;

endmodule

// ----- design/rsi_queue.sv -----
// Short FIFO that decouples the front end from the back end.
module rsi_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rsi_pkg::queue_entry_t  wr_data,
    input  logic                   pop,
    output rsi_pkg::queue_entry_t  rd_data,
    output rsi_pkg::queue_status_t status
);
    import rsi_pkg::*;

    localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    queue_entry_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_wr;
    logic              do_rd;

    assign do_wr = push && (count_reg != DEPTH_CNT);
    assign do_rd = pop && (count_reg != '0);

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.almost_full = (count_reg >= DEPTH_CNT - 1'b1);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != DEPTH_CNT))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && (count_reg != DEPTH_CNT)) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy did not follow a lone write");

endmodule

// ----- design/rsi_back.sv -----
// Back end: projection, discriminant, near root, hit point, normal and distance.
module rsi_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rsi_pkg::queue_status_t q_status,
    input  rsi_pkg::queue_entry_t  head,
    input  rsi_pkg::sphere_cfg_t   cfg,
    output logic                   pop,
    output logic                   done,
    output rsi_pkg::result_t       result
);
    import rsi_pkg::*;

    localparam logic [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic        rej;
        fix_t [2:0]  o;
        unit_t [2:0] u;
        logic [31:0] h;
    } root_side_t;

    typedef struct packed {
        logic        rej;
        fix_t [2:0]  psat;
        logic [2:0]  nneg;
        logic [2:0]  ovf;
        logic [30:0] hit_dist;
    } norm_side_t;

    // Stage 0: popped entry
    logic         v0_reg;
    queue_entry_t e0_reg;

    // Stages 1 to 6: projection and discriminant
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [PROD_W-1:0] prod1_reg [3];
    logic [63:0]              sqr1_reg [3];
    queue_entry_t             e1_reg, e2_reg;
    logic signed [ACC_W-1:0]  acc2_reg;
    logic [63:0]              oc2_2_reg, oc2_3_reg, oc2_4_reg, oc2_5_reg;
    root_side_t               side3_reg, side4_reg, side5_reg, side6_reg;
    logic [63:0]              h2_4_reg;
    logic [63:0]              r2_4_reg;
    logic [63:0]              a5_reg;
    logic [63:0]              dsc6_reg;

    logic             acc_neg;
    logic [ACC_W-1:0] acc_mag;
    logic [ACC_W-1:0] h_round;
    logic [31:0]      h_sat;
    logic [64:0]      a_sum;

    // Square root line
    logic [SQRT_STAGES-1:0] vsq_reg;
    root_side_t             side_sq_reg [SQRT_STAGES];
    logic [31:0]            sq_root;

    // Stages 7 to 11: root, hit point, normal dividend
    logic                     v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    logic                     rej7_reg, rej8_reg, rej9_reg, rej10_reg, rej11_reg;
    logic [31:0]              m7_reg, m8_reg;
    fix_t [2:0]               o7_reg;
    unit_t [2:0]              u7_reg;
    logic [PROD_W-1:0]        pm8_reg [3];
    logic [2:0]               uneg8_reg;
    fix_t [2:0]               o8_reg;
    logic signed [PT_W-1:0]   p9_reg [3];
    logic [30:0]              dist9_reg, dist10_reg, dist11_reg;
    logic signed [ND_W-1:0]   nd10_reg [3];
    fix_t [2:0]               psat10_reg, psat11_reg;
    logic [63:0]              num11_reg [3];
    logic [2:0]               nneg11_reg;
    logic [2:0]               ovf11_reg;

    logic [U_W-1:0]    u_mag [3];
    logic [PROD_W-1:0] p_off [3];
    logic [ND_W-1:0]   nd_mag [3];
    logic [63:0]       num_next [3];

    // Divider line
    logic [DIV_STAGES-1:0] vdv_reg;
    norm_side_t            side_dv_reg [DIV_STAGES];
    logic [31:0]           quot [3];

    // Stage 12: result
    logic    v12_reg;
    result_t result_reg;

    assign pop = !q_status.empty;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vsq_reg <= '0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            vdv_reg <= '0;
            v12_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= pop;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            vsq_reg <= {vsq_reg[SQRT_STAGES-2:0], v6_reg};
            v7_reg <= vsq_reg[SQRT_STAGES-1];
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            vdv_reg <= {vdv_reg[DIV_STAGES-2:0], v11_reg};
            v12_reg <= vdv_reg[DIV_STAGES-1];
        end
    end

    // Take the head of the queue
    always_ff @(posedge clk)
    begin
        if (pop)
            e0_reg <= head;
    end

    // Multiply offset by direction and by itself
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod1_reg[i] <= e0_reg.oc[i] * e0_reg.u[i];
            sqr1_reg[i] <= e0_reg.oc[i] * e0_reg.oc[i];
        end
        e1_reg <= e0_reg;
    end

    // Sum the dot product and the squared offset
    always_ff @(posedge clk)
    begin
        acc2_reg <= prod1_reg[0] + prod1_reg[1] + prod1_reg[2];
        oc2_2_reg <= sqr1_reg[0] + sqr1_reg[1] + sqr1_reg[2];
        e2_reg <= e1_reg;
    end

    // Round the projection, drop rays with the center behind
    always_comb
    begin
        acc_neg = acc2_reg[ACC_W-1];
        acc_mag = acc_neg ? ACC_W'(-acc2_reg) : ACC_W'(acc2_reg);
        h_round = (acc_mag + ACC_HALF) >> FRAC_BITS;
        if (acc_neg)
            h_sat = 32'd0;
        else if (h_round > ACC_W'(32'hFFFF_FFFF))
            h_sat = 32'hFFFF_FFFF;
        else
            h_sat = h_round[31:0];
    end

    always_ff @(posedge clk)
    begin
        side3_reg.rej <= e2_reg.reject || (acc_neg && (h_round != '0));
        side3_reg.o <= e2_reg.origin;
        side3_reg.u <= e2_reg.u;
        side3_reg.h <= h_sat;
        oc2_3_reg <= oc2_2_reg;
    end

    // Square projection and radius
    always_ff @(posedge clk)
    begin
        h2_4_reg <= side3_reg.h * side3_reg.h;
        r2_4_reg <= cfg.sphere_radius * cfg.sphere_radius;
        oc2_4_reg <= oc2_3_reg;
        side4_reg <= side3_reg;
    end

    // Add with saturation
    assign a_sum = {1'b0, h2_4_reg} + {1'b0, r2_4_reg};

    always_ff @(posedge clk)
    begin
        a5_reg <= a_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : a_sum[63:0];
        oc2_5_reg <= oc2_4_reg;
        side5_reg <= side4_reg;
    end

    // Form the discriminant, drop rays that miss
    always_ff @(posedge clk)
    begin
        dsc6_reg <= a5_reg - oc2_5_reg;
        side6_reg.o <= side5_reg.o;
        side6_reg.u <= side5_reg.u;
        side6_reg.h <= side5_reg.h;
        side6_reg.rej <= side5_reg.rej || (a5_reg < oc2_5_reg);
    end

    rsi_isqrt u_disc_sqrt (
        .clk      (clk),
        .radicand (dsc6_reg),
        .root     (sq_root)
    );

    // Hold ray data alongside the square root
    always_ff @(posedge clk)
    begin
        side_sq_reg[0] <= side6_reg;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            side_sq_reg[k] <= side_sq_reg[k-1];
        end
    end

    // Near root, drop rays whose root is not positive
    always_ff @(posedge clk)
    begin
        rej7_reg <= side_sq_reg[SQRT_STAGES-1].rej || (side_sq_reg[SQRT_STAGES-1].h <= sq_root);
        m7_reg <= side_sq_reg[SQRT_STAGES-1].h - sq_root;
        o7_reg <= side_sq_reg[SQRT_STAGES-1].o;
        u7_reg <= side_sq_reg[SQRT_STAGES-1].u;
    end

    // Scale the unit direction by the root
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_mag[i] = u7_reg[i][U_W-1] ? U_W'(-u7_reg[i]) : U_W'(u7_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pm8_reg[i] <= m7_reg * u_mag[i];
            uneg8_reg[i] <= u7_reg[i][U_W-1];
        end
        m8_reg <= m7_reg;
        o8_reg <= o7_reg;
        rej8_reg <= rej7_reg;
    end

    // Round the step and add it to the origin
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_off[i] = (pm8_reg[i] + PROD_HALF) >> FRAC_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (uneg8_reg[i])
                p9_reg[i] <= PT_W'(o8_reg[i]) - PT_W'(p_off[i]);
            else
                p9_reg[i] <= PT_W'(o8_reg[i]) + PT_W'(p_off[i]);
        end
        dist9_reg <= m8_reg[31] ? 31'h7FFF_FFFF : m8_reg[30:0];
        rej9_reg <= rej8_reg;
    end

    // Offset the hit point from the center and clamp the point
    always_ff @(posedge clk)
    begin
        nd10_reg[0] <= ND_W'(p9_reg[0]) - ND_W'(cfg.center_x);
        nd10_reg[1] <= ND_W'(p9_reg[1]) - ND_W'(cfg.center_y);
        nd10_reg[2] <= ND_W'(p9_reg[2]) - ND_W'(cfg.center_z);
        for (int i = 0; i < 3; i++)
        begin
            psat10_reg[i] <= sat32(64'(p9_reg[i]));
        end
        dist10_reg <= dist9_reg;
        rej10_reg <= rej9_reg;
    end

    // Form |offset| * one + radius / 2 and flag quotients past 32 bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nd_mag[i] = nd10_reg[i][ND_W-1] ? ND_W'(-nd10_reg[i]) : ND_W'(nd10_reg[i]);
            num_next[i] = (64'(nd_mag[i]) << FRAC_BITS) + 64'(cfg.sphere_radius >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num11_reg[i] <= num_next[i];
            nneg11_reg[i] <= nd10_reg[i][ND_W-1];
            ovf11_reg[i] <= (num_next[i] >= (64'(cfg.sphere_radius) << 32));
        end
        psat11_reg <= psat10_reg;
        dist11_reg <= dist10_reg;
        rej11_reg <= rej10_reg;
    end

    for (genvar i = 0; i < 3; i++) begin : g_normal_div
        rsi_div u_div (
            .clk      (clk),
            .dividend (num11_reg[i]),
            .divisor  ({1'b0, cfg.sphere_radius}),
            .quotient (quot[i])
        );
    end

    // Hold hit data alongside the dividers
    always_ff @(posedge clk)
    begin
        side_dv_reg[0].rej <= rej11_reg;
        side_dv_reg[0].psat <= psat11_reg;
        side_dv_reg[0].nneg <= nneg11_reg;
        side_dv_reg[0].ovf <= ovf11_reg;
        side_dv_reg[0].hit_dist <= dist11_reg;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            side_dv_reg[k] <= side_dv_reg[k-1];
        end
    end

    // Clamp the normal and mask everything on a miss
    always_ff @(posedge clk)
    begin
        fix_t n [3];
        for (int i = 0; i < 3; i++)
        begin
            if (cfg.sphere_radius == '0)
                n[i] = '0;
            else if (side_dv_reg[DIV_STAGES-1].ovf[i])
                n[i] = side_dv_reg[DIV_STAGES-1].nneg[i] ? fix_t'(FIX_MIN) : fix_t'(FIX_MAX);
            else if (side_dv_reg[DIV_STAGES-1].nneg[i])
                n[i] = (quot[i] > 32'h8000_0000) ? fix_t'(FIX_MIN) : fix_t'(-quot[i]);
            else
                n[i] = quot[i][31] ? fix_t'(FIX_MAX) : fix_t'(quot[i]);
        end
        if (side_dv_reg[DIV_STAGES-1].rej)
        begin
            result_reg <= '0;
        end
        else
        begin
            result_reg.hit <= 1'b1;
            result_reg.point_x <= side_dv_reg[DIV_STAGES-1].psat[0];
            result_reg.point_y <= side_dv_reg[DIV_STAGES-1].psat[1];
            result_reg.point_z <= side_dv_reg[DIV_STAGES-1].psat[2];
            result_reg.normal_x <= n[0];
            result_reg.normal_y <= n[1];
            result_reg.normal_z <= n[2];
            result_reg.hit_distance <= side_dv_reg[DIV_STAGES-1].hit_dist;
        end
    end

    assign done = v12_reg;
    assign result = result_reg;

endmodule

// ----- verif/tb_ray_sphere_intersect_unit.sv -----
// Self-checking testbench of the ray/sphere intersection unit.
module tb_ray_sphere_intersect_unit;
    import rsi_pkg::*;

    localparam int PIPE_WAIT = 160;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 265;
    localparam int NUM_PHASES = 6;
    localparam logic signed [63:0] Q_ONE = 64'sd65536;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    ray_t        ray = '0;
    logic        done;
    result_t     result;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Shadow copy of the sphere registers
    logic signed [63:0] sphere_ctr [3];
    logic [63:0]        sphere_rad;

    ray_t    pending_rays [$];
    result_t expected_hits [$];
    int      idle_pct = 19;
    int      errors = 0;
    int      rays_sent = 0;
    int      results_seen = 0;
    int      hits_seen = 0;
    int      cycles = 0;

    ray_sphere_intersect_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ray       (ray),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clamp to the 32-bit signed range
    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Divide by 2^16, round half away from zero
    function automatic logic signed [63:0] round_q(input logic signed [63:0] x);
        logic [63:0] mg;
        mg = (x < 0) ? 64'(-x) : 64'(x);
        mg = (mg + 64'd32768) >> 16;
        return (x < 0) ? -$signed(mg) : $signed(mg);
    endfunction

    // Divide by den, round half away from zero
    function automatic logic signed [63:0] round_div(input logic signed [63:0] num,
                                                     input logic [63:0] den);
        logic [63:0] mg;
        mg = (num < 0) ? 64'(-num) : 64'(num);
        mg = (mg + den / 2) / den;
        return (num < 0) ? -$signed(mg) : $signed(mg);
    endfunction

    // Integer square root, floor
    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Expected result of one ray against the current sphere
    function automatic result_t trace_ray(input ray_t r);
        logic signed [63:0] o [3];
        logic signed [63:0] d [3];
        logic signed [63:0] u [3];
        logic signed [63:0] oc [3];
        logic signed [63:0] p [3];
        logic signed [63:0] acc;
        logic signed [63:0] h;
        logic signed [63:0] m;
        logic [63:0] s;
        logic [63:0] oc2;
        logic [63:0] diff;
        logic [63:0] len;
        logic [63:0] h2;
        logic [63:0] a;
        logic [63:0] sq;
        result_t res;
        res = '0;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
        s = '0;
        for (int i = 0; i < 3; i++)
            s = s + 64'(d[i] * d[i]);
        if (s == 0)
            return res;
        diff = (s > 64'h1_0000_0000) ? s - 64'h1_0000_0000 : 64'h1_0000_0000 - s;
        if (diff <= (64'h1_0000_0000 >> 12))
        begin
            for (int i = 0; i < 3; i++)
                u[i] = d[i];
        end
        else
        begin
            len = root64(s);
            for (int i = 0; i < 3; i++)
                u[i] = round_div(d[i] * Q_ONE, len);
        end
        acc = '0;
        oc2 = '0;
        for (int i = 0; i < 3; i++)
        begin
            oc[i] = clamp32(sphere_ctr[i] - o[i]);
            acc = acc + oc[i] * u[i];
            oc2 = oc2 + 64'(oc[i] * oc[i]);
        end
        h = round_q(acc);
        if (h < 0)
            return res;
        if (h > 64'sd4294967295)
            h = 64'sd4294967295;
        h2 = 64'(h) * 64'(h);
        a = h2 + sphere_rad * sphere_rad;
        if (a < h2)
            a = '1;
        if (a < oc2)
            return res;
        sq = root64(a - oc2);
        if (64'(h) <= sq)
            return res;
        m = h - $signed(sq);
        for (int i = 0; i < 3; i++)
            p[i] = o[i] + round_q(m * u[i]);
        res.hit = 1'b1;
        res.point_x = fix_t'(clamp32(p[0]));
        res.point_y = fix_t'(clamp32(p[1]));
        res.point_z = fix_t'(clamp32(p[2]));
        if (sphere_rad != 0)
        begin
            res.normal_x = fix_t'(clamp32(round_div((p[0] - sphere_ctr[0]) * Q_ONE, sphere_rad)));
            res.normal_y = fix_t'(clamp32(round_div((p[1] - sphere_ctr[1]) * Q_ONE, sphere_rad)));
            res.normal_z = fix_t'(clamp32(round_div((p[2] - sphere_ctr[2]) * Q_ONE, sphere_rad)));
        end
        res.hit_distance = (m > 64'sd2147483647) ? 31'h7FFF_FFFF : m[30:0];
        return res;
    endfunction

    function automatic logic signed [63:0] rand_span(input logic signed [63:0] span);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return $signed(raw % (2 * span + 1)) - span;
    endfunction

    // Ray from near the sphere aimed roughly at it
    function automatic ray_t make_aimed_ray();
        logic signed [63:0] spread;
        logic signed [63:0] org [3];
        logic signed [63:0] dv [3];
        int k;
        ray_t r;
        spread = $signed(sphere_rad) * 4 + 64'sd1048576;
        if (spread > 64'sd2147483647)
            spread = 64'sd2147483647;
        k = $urandom_range(8);
        for (int i = 0; i < 3; i++)
        begin
            org[i] = clamp32(sphere_ctr[i] + rand_span(spread));
            dv[i] = clamp32((sphere_ctr[i] + rand_span($signed(sphere_rad)) - org[i]) >>> k);
        end
        r.origin_x = fix_t'(org[0]); r.origin_y = fix_t'(org[1]); r.origin_z = fix_t'(org[2]);
        r.dir_x = fix_t'(dv[0]);     r.dir_y = fix_t'(dv[1]);     r.dir_z = fix_t'(dv[2]);
        return r;
    endfunction

    // Axis ray passing within half a radius of the center, direction close to unit length
    function automatic ray_t make_axis_ray();
        logic signed [63:0] org [3];
        logic signed [63:0] dv [3];
        logic signed [63:0] sgn;
        int ax;
        ray_t r;
        ax = $urandom_range(2);
        sgn = $urandom_range(1) ? 64'sd1 : -64'sd1;
        for (int i = 0; i < 3; i++)
        begin
            org[i] = clamp32(sphere_ctr[i] + rand_span($signed(sphere_rad) / 2));
            dv[i] = '0;
        end
        org[ax] = clamp32(sphere_ctr[ax] - sgn * ($signed(sphere_rad) * 2
                  + $signed(64'($urandom_range(1 << 20)))));
        dv[ax] = sgn * (Q_ONE + rand_span(16));
        r.origin_x = fix_t'(org[0]); r.origin_y = fix_t'(org[1]); r.origin_z = fix_t'(org[2]);
        r.dir_x = fix_t'(dv[0]);     r.dir_y = fix_t'(dv[1]);     r.dir_z = fix_t'(dv[2]);
        return r;
    endfunction

    function automatic ray_t make_ray(input int kind);
        ray_t r;
        if (kind < 70)
            return make_aimed_ray();
        if (kind < 82)
            return make_axis_ray();
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind < 90)
            r.dir_x = fix_t'($signed(r.dir_x) >>> $urandom_range(31));
        return r;
    endfunction

    function automatic ray_t ray_of(input logic signed [63:0] ox, input logic signed [63:0] oy,
                                    input logic signed [63:0] oz, input logic signed [63:0] dx,
                                    input logic signed [63:0] dy, input logic signed [63:0] dz);
        ray_t r;
        r.origin_x = fix_t'(ox); r.origin_y = fix_t'(oy); r.origin_z = fix_t'(oz);
        r.dir_x = fix_t'(dx);    r.dir_y = fix_t'(dy);    r.dir_z = fix_t'(dz);
        return r;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_RADIUS)
            sphere_rad = 64'(value[30:0]);
        else
            sphere_ctr[idx] = $signed(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_sphere(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cz, input logic [31:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
    endtask

    // Hold until the pipeline has drained completely
    task automatic drain();
        wait (pending_rays.size() == 0 && expected_hits.size() == 0);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Drive rays; a transaction completes on start with busy low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            ray <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_hits.push_back(trace_ray(ray));
                void'(pending_rays.pop_front());
                rays_sent++;
            end
            if (pending_rays.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                ray <= pending_rays[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Check each result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result, got %h", $time, result);
                errors++;
            end
            else
            begin
                result_t exp_r;
                exp_r = expected_hits.pop_front();
                if (exp_r.hit)
                    hits_seen++;
                check_field("hit", 32'(exp_r.hit), 32'(result.hit));
                check_field("point_x", exp_r.point_x, result.point_x);
                check_field("point_y", exp_r.point_y, result.point_y);
                check_field("point_z", exp_r.point_z, result.point_z);
                check_field("normal_x", exp_r.normal_x, result.normal_x);
                check_field("normal_y", exp_r.normal_y, result.normal_y);
                check_field("normal_z", exp_r.normal_z, result.normal_z);
                check_field("hit_distance", 32'(exp_r.hit_distance), 32'(result.hit_distance));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_hits.size());
            $display("tb_ray_sphere_intersect_unit failed");
            $finish;
        end
    end

    initial
    begin
        logic signed [63:0] u1;
        u1 = Q_ONE;
        sphere_ctr[0] = 0;
        sphere_ctr[1] = 0;
        sphere_ctr[2] = 0;
        sphere_rad = 64'd65536;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_pct = (ph < 2) ? 19 : (ph < 4) ? 75 : 0;
            case (ph)
                1: load_sphere($urandom_range(1 << 23) - (1 << 22),
                               $urandom_range(1 << 23) - (1 << 22),
                               $urandom_range(1 << 23) - (1 << 22), $urandom_range(1 << 21, 1));
                2: load_sphere($urandom_range(1 << 21), 32'hFFF0_0000, 32'd0, 32'd0);
                3: load_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                4: load_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1);
                5: load_sphere($urandom, $urandom, $urandom, $urandom);
                default: ;
            endcase
            if (ph == 0)
            begin
                // Directed rays against the unit sphere at the origin
                pending_rays.push_back(ray_of(-5 * u1, 0, 0, 0, 0, 0));
                pending_rays.push_back(ray_of(-5 * u1, 0, 0, u1, 0, 0));
                pending_rays.push_back(ray_of(0, -5 * u1, 0, 0, u1, 0));
                pending_rays.push_back(ray_of(0, 0, 5 * u1, 0, 0, -u1));
                pending_rays.push_back(ray_of(-5 * u1, 0, 0, 3 * u1, 0, 0));
                pending_rays.push_back(ray_of(-5 * u1, 0, 0, u1 + 8, 0, 0));
                pending_rays.push_back(ray_of(-5 * u1, 0, 0, -u1, 0, 0));
                pending_rays.push_back(ray_of(-5 * u1, 3 * u1, 0, u1, 0, 0));
                pending_rays.push_back(ray_of(-5 * u1, u1, 0, u1, 0, 0));
                pending_rays.push_back(ray_of(0, 0, 0, u1, 0, 0));
                pending_rays.push_back(ray_of(u1 / 2, 0, 0, u1, 0, 0));
                pending_rays.push_back(ray_of(-3 * u1, -3 * u1, -3 * u1, u1, u1, u1));
                pending_rays.push_back(ray_of(-5 * u1, 0, 0, 32'sh7FFF_FFFF, 0, 0));
                pending_rays.push_back(ray_of(-5 * u1, 0, 0, -64'sd2147483648, 0, 0));
                pending_rays.push_back(ray_of(5 * u1, 0, 0, -64'sd2147483648, 0, 0));
                pending_rays.push_back(ray_of(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                                              64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
                pending_rays.push_back(ray_of(-64'sd2147483648, -64'sd2147483648,
                                              -64'sd2147483648, -64'sd2147483648,
                                              -64'sd2147483648, -64'sd2147483648));
                pending_rays.push_back(ray_of(-64'sd2147483648, -64'sd2147483648,
                                              -64'sd2147483648, 64'sd2147483647,
                                              64'sd2147483647, 64'sd2147483647));
                pending_rays.push_back(ray_of(64'sd2147483647, 0, 0, -u1, 0, 0));
                pending_rays.push_back(ray_of(-5 * u1, 0, 0, u1, 1, -1));
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                pending_rays.push_back(make_ray($urandom_range(99)));
            drain();
        end

        $display("sent %0d rays over %0d sphere settings, %0d results checked, %0d hits",
                 rays_sent, NUM_PHASES, results_seen, hits_seen);
        if (errors == 0)
            $display("tb_ray_sphere_intersect_unit passed");
        else
            $display("tb_ray_sphere_intersect_unit failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/rsi_pkg.sv
design/rsi_isqrt.sv
design/rsi_div.sv
design/rsi_front.sv
design/rsi_queue.sv
design/rsi_back.sv
design/ray_sphere_intersect_unit.sv
verif/tb_ray_sphere_intersect_unit.sv
